// File: sv/hbtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat timeout monitor package
// Shared constants and the per-lane status type.
// ----------------------------------------------------------------------------
package hbtm_pkg;

    localparam int CNT_W     = 16;
    localparam int THR_W     = 16;
    localparam int TIME_W    = 32;
    localparam int IDX_W     = 3;
    localparam int GRP_W     = 2;
    localparam int GROUP_MAX = 8;

    localparam logic [CNT_W-1:0] SAT_MAX = 16'hFFFF;
    localparam logic [THR_W-1:0] THR_RESET = 16'd10;

    localparam logic [GRP_W-1:0] GROUP_CP  = 2'd0;
    localparam logic [GRP_W-1:0] GROUP_PSM = 2'd1;
    localparam logic [GRP_W-1:0] GROUP_SSM = 2'd2;

    localparam logic [1:0] REG_CP_THR  = 2'd0;
    localparam logic [1:0] REG_PSM_THR = 2'd1;
    localparam logic [1:0] REG_SSM_THR = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] stale_count;
        logic             fire;
    } lane_out_t;

endpackage

// File: sv/hbtm_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat monitor lane
// Stale counter and missing flag of one module, updated once per tick.
// ----------------------------------------------------------------------------
module hbtm_lane
    import hbtm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             alive,
    input  logic [THR_W-1:0] threshold,
    output lane_out_t        status
);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             miss_reg;
    logic             miss_next;
    logic             fire;

    always_comb
    begin
        if (alive)
        begin
            cnt_next = '0;
        end
        else if (cnt_reg == SAT_MAX)
        begin
            cnt_next = cnt_reg;
        end
        else
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        fire      = !alive && (cnt_next == threshold) && !miss_reg;
        miss_next = !alive && (miss_reg || fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            miss_reg <= 1'b0;
        end
        else if (step)
        begin
            cnt_reg  <= cnt_next;
            miss_reg <= miss_next;
        end
    end

    assign status.stale_count = cnt_reg;
    assign status.fire        = fire;

endmodule

// File: sv/hbtm_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat monitor event merger
// Latches the lanes' fault bits of one tick and sends one event per cycle
// while m_axis does not stall, lowest lane first, through an output register.
// ----------------------------------------------------------------------------
module hbtm_merge
    import hbtm_pkg::*;
#(
    parameter int PSM_LANES = 8,
    parameter int SSM_LANES = 8,
    localparam int LANES    = 1 + PSM_LANES + SSM_LANES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [TIME_W-1:0] tick_time,
    input  lane_out_t         lanes [LANES],
    output logic              idle,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [55:0]       m_axis_tdata,  // module_index, event_time, stale_count
    output logic [1:0]        m_axis_tuser,  // module_group
    output logic              m_axis_tlast
);

    logic [LANES-1:0]  pend_reg;
    logic [TIME_W-1:0] time_reg;
    logic              out_valid_reg;
    logic [GRP_W-1:0]  out_grp_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [TIME_W-1:0] out_time_reg;
    logic [CNT_W-1:0]  out_cnt_reg;
    logic              out_last_reg;

    logic [LANES-1:0]  fire_vec;
    logic [LANES-1:0]  pick;
    logic [LANES-1:0]  pend_left;
    logic [GRP_W-1:0]  lane_grp [LANES];
    logic [IDX_W-1:0]  lane_idx [LANES];
    logic [GRP_W-1:0]  sel_grp;
    logic [IDX_W-1:0]  sel_idx;
    logic [CNT_W-1:0]  sel_cnt;
    logic              can_load;

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane_id
        localparam int IDX = (k == 0) ? 0 : ((k <= PSM_LANES) ? k - 1 : k - 1 - PSM_LANES);
        assign lane_grp[k] = (k == 0) ? GROUP_CP : ((k <= PSM_LANES) ? GROUP_PSM : GROUP_SSM);
        assign lane_idx[k] = IDX_W'(IDX);
        assign fire_vec[k] = lanes[k].fire;
    end

    always_comb
    begin
        pick      = pend_reg & (~pend_reg + 1'b1);
        pend_left = pend_reg & ~pick;
        sel_grp   = '0;
        sel_idx   = '0;
        sel_cnt   = '0;
        for (int k = 0; k < LANES; k++)
        begin
            sel_grp = sel_grp | (lane_grp[k] & {GRP_W{pick[k]}});
            sel_idx = sel_idx | (lane_idx[k] & {IDX_W{pick[k]}});
            sel_cnt = sel_cnt | (lanes[k].stale_count & {CNT_W{pick[k]}});
        end
        can_load = !out_valid_reg || m_axis_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                pend_reg <= fire_vec;
            end
            else if (can_load)
            begin
                pend_reg <= pend_left;
            end
            if (can_load)
            begin
                out_valid_reg <= |pend_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            time_reg <= tick_time;
        end
        if (can_load && |pend_reg)
        begin
            out_grp_reg  <= sel_grp;
            out_idx_reg  <= sel_idx;
            out_time_reg <= time_reg;
            out_cnt_reg  <= sel_cnt;
            out_last_reg <= (pend_left == '0);
        end
    end

    assign idle          = (pend_reg == '0);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_cnt_reg, out_time_reg, out_idx_reg};
    assign m_axis_tuser  = out_grp_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: sv/module_heartbeat_timeout_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat timeout monitor
// Tracks stale heartbeats of a control module, power modules and sensor
// modules, and reports each module once when it goes missing.
//
// Channel   Direction  Contents
// s_axis    in         one tick: alive bits and timestamp
// m_axis    out        one fault event per missing module, tlast on the last
// cfg       in         group thresholds, written by index
//
// When a tick is taken, all lanes are updated in parallel.
// Its events then leave one per cycle while m_axis does not stall; a tick has at most 17 events.
// s_axis_tready is low while events of the previous tick are still queued.
// Reset clears all counters and flags and sets every threshold to 10.
// A stalled m_axis holds the event register and the queue.
// ----------------------------------------------------------------------------
module module_heartbeat_timeout_monitor
    import hbtm_pkg::*;
#(
    parameter int PSM_COUNT = 8,
    parameter int SSM_COUNT = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [55:0]      s_axis_tdata,   // cp_alive, psm_alive, ssm_alive, tick_time
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // module_index, event_time, stale_count
    output logic [1:0]       m_axis_tuser,   // module_group
    output logic             m_axis_tlast,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [THR_W-1:0] cfg_wdata
);

    localparam int PSM_LANES = (PSM_COUNT > GROUP_MAX) ? GROUP_MAX : PSM_COUNT;
    localparam int SSM_LANES = (SSM_COUNT > GROUP_MAX) ? GROUP_MAX : SSM_COUNT;
    localparam int LANES     = 1 + PSM_LANES + SSM_LANES;

    logic [THR_W-1:0] cp_thr_reg;
    logic [THR_W-1:0] psm_thr_reg;
    logic [THR_W-1:0] ssm_thr_reg;

    logic             step;
    logic             idle;
    logic             cp_alive;
    logic [7:0]       psm_alive;
    logic [7:0]       ssm_alive;
    logic [TIME_W-1:0] tick_time;
    logic [LANES-1:0] alive_vec;
    logic [THR_W-1:0] lane_thr [LANES];
    lane_out_t        lane_status [LANES];

    assign cp_alive  = s_axis_tdata[0];
    assign psm_alive = s_axis_tdata[8:1];
    assign ssm_alive = s_axis_tdata[16:9];
    assign tick_time = s_axis_tdata[48:17];

    assign s_axis_tready = idle;
    assign step          = s_axis_tvalid && idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_thr_reg  <= THR_RESET;
            psm_thr_reg <= THR_RESET;
            ssm_thr_reg <= THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CP_THR:  cp_thr_reg  <= cfg_wdata;
                REG_PSM_THR: psm_thr_reg <= cfg_wdata;
                REG_SSM_THR: ssm_thr_reg <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    assign alive_vec[0] = cp_alive;
    assign lane_thr[0]  = cp_thr_reg;

    for (genvar i = 0; i < PSM_LANES; i++)
    begin : g_psm_map
        assign alive_vec[1 + i] = psm_alive[i];
        assign lane_thr[1 + i]  = psm_thr_reg;
    end

    for (genvar j = 0; j < SSM_LANES; j++)
    begin : g_ssm_map
        assign alive_vec[1 + PSM_LANES + j] = ssm_alive[j];
        assign lane_thr[1 + PSM_LANES + j]  = ssm_thr_reg;
    end

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        hbtm_lane u_lane
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (step),
            .alive     (alive_vec[k]),
            .threshold (lane_thr[k]),
            .status    (lane_status[k])
        );
    end

    hbtm_merge
    #(
        .PSM_LANES (PSM_LANES),
        .SSM_LANES (SSM_LANES)
    )
    u_merge
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (step),
        .tick_time     (tick_time),
        .lanes         (lane_status),
        .idle          (idle),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTH
    // An event that is not the last of its tick is followed at once by the next one.
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("event queue stalled inside a tick");

    // Counters of the first and last lanes must not move while events of a tick are still queued.
    a_counts_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |=> $stable(lane_status[0].stale_count)
                           && $stable(lane_status[LANES-1].stale_count))
        else $error("lane counter changed while events were pending");

    // A threshold of zero never fires, so every event carries a nonzero count.
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[50:35] != '0)
        else $error("event with zero stale count");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat timeout monitor testbench
// Sends ticks of alive bits and timestamps. A scoreboard tracks every stale
// counter and missing flag and checks each fault event in order. The run
// covers several threshold settings, both stream sides idle and stall at
// random, and one run lowers a threshold below a counter that is still rising.
// ----------------------------------------------------------------------------
module tb;
    import hbtm_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 24;
    localparam int          HOLD_CYCLES    = 240;
    localparam logic [1:0]  REG_NONE       = 2'd3;

    typedef struct {
        logic [GRP_W-1:0]  module_group;
        logic [IDX_W-1:0]  module_index;
        logic [TIME_W-1:0] event_time;
        logic [CNT_W-1:0]  stale_count;
        logic              last_event;
    } fault_t;

    class fault_scoreboard;
        logic [THR_W-1:0] threshold [3];
        logic [CNT_W-1:0] stale [3][GROUP_MAX];
        bit               missing [3][GROUP_MAX];
        fault_t           pending_faults [$];
        int               errors;

        function new();
            threshold = '{THR_RESET, THR_RESET, THR_RESET};
            foreach (stale[g, i])
            begin
                stale[g][i] = '0;
                missing[g][i] = 1'b0;
            end
            errors = 0;
        endfunction

        function void set_threshold(logic [1:0] index, logic [THR_W-1:0] value);
            case (index)
                REG_CP_THR:  threshold[GROUP_CP]  = value;
                REG_PSM_THR: threshold[GROUP_PSM] = value;
                REG_SSM_THR: threshold[GROUP_SSM] = value;
                default: ;
            endcase
        endfunction

        function void age_module(int grp, int idx, bit alive, logic [TIME_W-1:0] t);
            fault_t f;
            if (alive)
            begin
                stale[grp][idx] = '0;
                missing[grp][idx] = 1'b0;
                return;
            end
            if (stale[grp][idx] != SAT_MAX)
                stale[grp][idx] = stale[grp][idx] + 1'b1;
            if (stale[grp][idx] == threshold[grp] && !missing[grp][idx])
            begin
                missing[grp][idx] = 1'b1;
                f.module_group = GRP_W'(grp);
                f.module_index = IDX_W'(idx);
                f.event_time   = t;
                f.stale_count  = stale[grp][idx];
                f.last_event   = 1'b0;
                pending_faults.push_back(f);
            end
        endfunction

        function void note_tick(bit cp, logic [7:0] psm, logic [7:0] ssm,
                                logic [TIME_W-1:0] t);
            fault_t f;
            int     first;
            first = pending_faults.size();
            age_module(GROUP_CP, 0, cp, t);
            for (int i = 0; i < GROUP_MAX; i++)
                age_module(GROUP_PSM, i, psm[i], t);
            for (int i = 0; i < GROUP_MAX; i++)
                age_module(GROUP_SSM, i, ssm[i], t);
            if (pending_faults.size() > first)
            begin
                f = pending_faults.pop_back();
                f.last_event = 1'b1;
                pending_faults.push_back(f);
            end
        endfunction

        function int pending();
            return pending_faults.size();
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_fault(logic [GRP_W-1:0] grp, logic [IDX_W-1:0] idx,
                         logic [TIME_W-1:0] t, logic [CNT_W-1:0] cnt, logic last);
            fault_t f;
            if (pending_faults.size() == 0)
            begin
                report($sformatf("unexpected fault group %0d index %0d", grp, idx));
                return;
            end
            f = pending_faults.pop_front();
            if (grp !== f.module_group)
                report($sformatf("module_group %0d, expected %0d", grp, f.module_group));
            if (idx !== f.module_index)
                report($sformatf("module_index %0d, expected %0d", idx, f.module_index));
            if (t !== f.event_time)
                report($sformatf("event_time %h, expected %h", t, f.event_time));
            if (cnt !== f.stale_count)
                report($sformatf("stale_count %0d, expected %0d", cnt, f.stale_count));
            if (last !== f.last_event)
                report($sformatf("last_event %b, expected %b", last, f.last_event));
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [55:0]      s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [55:0]      m_axis_tdata;
    logic [1:0]       m_axis_tuser;
    logic             m_axis_tlast;
    logic             cfg_wr_en;
    logic [1:0]       cfg_index;
    logic [THR_W-1:0] cfg_wdata;

    fault_scoreboard sb;
    bit              tx_burst;
    bit              hold_req;
    int              idle_cycles;

    module_heartbeat_timeout_monitor u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin : monitor
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_tick(s_axis_tdata[0], s_axis_tdata[8:1], s_axis_tdata[16:9],
                             s_axis_tdata[48:17]);
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_fault(m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[34:3],
                               m_axis_tdata[50:35], m_axis_tlast);
                moved = 1'b1;
            end
            if (cfg_wr_en)
            begin
                sb.set_threshold(cfg_index, cfg_wdata);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin : receiver
        int gap;
        bit rx_burst;
        m_axis_tready = 1'b0;
        rx_burst = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            if ($urandom_range(0, 63) == 0)
                rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
            @(negedge clk);
        end
    end

    task automatic send_tick(bit cp, logic [7:0] psm, logic [7:0] ssm,
                             logic [TIME_W-1:0] t);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, t, ssm, psm, cp};
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [THR_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_thresholds(logic [THR_W-1:0] cp, logic [THR_W-1:0] psm,
                                    logic [THR_W-1:0] ssm);
        write_reg(REG_CP_THR, cp);
        write_reg(REG_PSM_THR, psm);
        write_reg(REG_SSM_THR, ssm);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [7:0] alive_from(logic [7:0] dead);
        logic [7:0] bits;
        int         roll;
        roll = $urandom_range(0, 15);
        bits = ~dead;
        if (roll == 0)
            bits = 8'($urandom);
        else if (roll < 4)
            bits = bits | (8'($urandom) & dead);
        else if (roll < 6)
            bits = bits & ~(8'd1 << $urandom_range(0, 7));
        return bits;
    endfunction

    initial
    begin : stimulus
        bit         cp_dead;
        bit         cp;
        logic [7:0] psm_dead;
        logic [7:0] ssm_dead;
        sb = new();
        tx_burst = 1'b0;
        hold_req = 1'b0;
        idle_cycles = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_CP_THR;
        cfg_wdata = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // All modules go silent together, so every group fires on the same tick.
        send_tick(1'b1, 8'hFF, 8'hFF, 32'h0000_0000);
        for (int k = 0; k < 10; k++)
            send_tick(1'b0, 8'h00, 8'h00, (k == 9) ? 32'hFFFF_FFFF : $urandom);
        send_tick(1'b0, 8'h00, 8'h00, 32'h0000_0000);
        send_tick(1'b1, 8'hAA, 8'h55, $urandom);
        drain();
        write_thresholds(16'd1, 16'd1, 16'd0);
        write_reg(REG_NONE, 16'hFFFF);
        send_tick(1'b0, 8'h00, 8'h00, $urandom);
        send_tick(1'b0, 8'h00, 8'h00, $urandom);
        send_tick(1'b1, 8'h0F, 8'hF0, $urandom);
        send_tick(1'b0, 8'h00, 8'h00, $urandom);
        send_tick(1'b0, 8'hFF, 8'h00, 32'hFFFF_FFFF);

        for (int phase = 0; phase < 6; phase++)
        begin
            drain();
            case (phase)
                0: write_thresholds(16'd0, 16'd0, 16'd0);
                1: write_thresholds(16'd1, 16'd1, 16'd1);
                default: write_thresholds(16'($urandom_range(1, 8)),
                                          16'($urandom_range(1, 8)),
                                          16'($urandom_range(1, 8)));
            endcase
            tx_burst = (phase == 3);
            if (phase == 1)
                hold_req = 1'b1;
            for (int n = 0; n < 72; n++)
            begin
                if (n % 16 == 0)
                begin
                    cp_dead  = $urandom_range(0, 1);
                    psm_dead = 8'($urandom);
                    ssm_dead = 8'($urandom);
                end
                cp = cp_dead ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 15) != 0);
                send_tick(cp, alive_from(psm_dead), alive_from(ssm_dead), $urandom);
            end
        end

        // The control counter climbs under a high threshold, then the threshold drops.
        drain();
        tx_burst = 1'b1;
        send_tick(1'b1, 8'hFF, 8'hFF, $urandom);
        drain();
        write_thresholds(16'd30, 16'd30, 16'd1);
        for (int n = 0; n < 20; n++)
            send_tick(1'b0, 8'h7F, 8'hFE, $urandom);
        drain();
        // The control counter now sits above its new threshold and stays quiet.
        write_reg(REG_CP_THR, 16'd5);
        for (int n = 0; n < 5; n++)
            send_tick(1'b0, 8'h7F, 8'hFE, $urandom);
        send_tick(1'b1, 8'hFF, 8'hFF, $urandom);
        tx_burst = 1'b0;
        for (int n = 0; n < 6; n++)
            send_tick(1'b0, 8'hFF, 8'hFF, $urandom);
        drain();

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: filelist.f
sv/hbtm_pkg.sv
sv/hbtm_lane.sv
sv/hbtm_merge.sv
sv/module_heartbeat_timeout_monitor.sv
tb/tb.sv
